// ===== hdl/covering_circle_remover_assert.svh =====
// Assertion macros for the files that check their own logic.
`ifndef COVERING_CIRCLE_REMOVER_ASSERT_SVH
`define COVERING_CIRCLE_REMOVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("covering circle remover: check failed");

// Consequent must hold in the cycle after the antecedent.
`define CCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("covering circle remover: check failed");

`endif

// ===== hdl/ccr_pkg.sv =====
`default_nettype none

package ccr_pkg;

    // Field widths fixed by the transaction format.
    localparam int unsigned COORD_BITS      = 24;
    localparam int unsigned RAD_BITS        = COORD_BITS - 1;
    localparam int unsigned IDX_BITS        = 6;
    localparam int unsigned MAX_CIRCLES_DEF = 64;

    // Input transaction.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic [RAD_BITS-1:0]          radius;
        logic                         last_circle;
    } t_circle_in;

    // Result transaction.
    typedef struct packed {
        logic [IDX_BITS-1:0]          circle_index;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [RAD_BITS-1:0]          out_radius;
        logic                         last_survivor;
    } t_circle_out;

    // One stored circle.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [RAD_BITS-1:0]          radius;
    } t_circle;

    // Tag of a pair under test: circle a is the candidate container.
    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] a_idx;
        logic [IDX_BITS-1:0] b_idx;
    } t_pair;

    // Containment found: circle a_idx must be dropped.
    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] a_idx;
    } t_hit;

endpackage

`default_nettype wire

// ===== hdl/ccr_mem.sv =====
`default_nettype none

// Circle store: one write port, one read port with registered data.
module ccr_mem #(
    parameter int unsigned DEPTH = ccr_pkg::MAX_CIRCLES_DEF,
    parameter int unsigned AW    = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire ccr_pkg::t_circle i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output ccr_pkg::t_circle     o_rdata
);

    ccr_pkg::t_circle r_mem [DEPTH];
    ccr_pkg::t_circle r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/ccr_cmp.sv =====
`default_nettype none

// Containment test pipeline: does circle a wholly contain circle b, and
// does b rank after a? Three register stages: differences, squares, compare.
module ccr_cmp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ccr_pkg::t_pair   i_pair,
    input  wire ccr_pkg::t_circle i_a,
    input  wire ccr_pkg::t_circle i_b,
    output ccr_pkg::t_hit         o_hit
);

    localparam int unsigned CW = ccr_pkg::COORD_BITS;
    localparam int unsigned RW = ccr_pkg::RAD_BITS;
    localparam int unsigned XW = ccr_pkg::IDX_BITS;

    // Stage 1 next values
    logic [CW:0]   n_dxs, n_dys, n_dxn, n_dyn;
    logic [CW-1:0] n_dx, n_dy;
    logic [RW-1:0] n_dr;
    logic          n_rank_ok;

    // Stage registers
    logic          r1_valid, r2_valid;
    logic [XW-1:0] r1_a, r2_a;
    logic [CW-1:0] r1_dx, r1_dy;
    logic [RW-1:0] r1_dr;
    logic [2*CW-1:0] r2_dx2, r2_dy2;
    logic [2*RW-1:0] r2_dr2;
    logic [2*CW:0]   n_sum;
    logic            n_fits;
    logic            r_hit_valid;
    logic [XW-1:0]   r_hit_a;

    // Absolute center differences and the rank test.
    always_comb begin
        n_dxs = {i_a.x[CW-1], i_a.x} - {i_b.x[CW-1], i_b.x};
        n_dys = {i_a.y[CW-1], i_a.y} - {i_b.y[CW-1], i_b.y};
        n_dxn = ~n_dxs + (CW+1)'(1);
        n_dyn = ~n_dys + (CW+1)'(1);
        n_dx  = n_dxs[CW] ? n_dxn[CW-1:0] : n_dxs[CW-1:0];
        n_dy  = n_dys[CW] ? n_dyn[CW-1:0] : n_dys[CW-1:0];
        n_dr  = i_a.radius - i_b.radius;
        // A larger radius ranks first; equal radii rank by lower position.
        n_rank_ok = (i_a.radius > i_b.radius) ||
                    ((i_a.radius == i_b.radius) && (i_pair.a_idx < i_pair.b_idx));
    end

    // Final compare: dx^2 + dy^2 <= dr^2.
    always_comb begin
        n_sum  = {1'b0, r2_dx2} + {1'b0, r2_dy2};
        n_fits = n_sum <= (2*CW+1)'(r2_dr2);
    end

    // Stage valids and the result flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_hit_valid <= 1'b0;
        end else begin
            r1_valid    <= i_pair.valid && n_rank_ok;
            r2_valid    <= r1_valid;
            r_hit_valid <= r2_valid && n_fits;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r1_a    <= i_pair.a_idx;
        r1_dx   <= n_dx;
        r1_dy   <= n_dy;
        r1_dr   <= n_dr;
        r2_a    <= r1_a;
        r2_dx2  <= r1_dx * r1_dx;
        r2_dy2  <= r1_dy * r1_dy;
        r2_dr2  <= r1_dr * r1_dr;
        r_hit_a <= r2_a;
    end

    assign o_hit = {r_hit_valid, r_hit_a};

endmodule

`default_nettype wire

// ===== hdl/covering_circle_remover.sv =====
`default_nettype none

// Covering circle remover.
// Load a set of circles with one transaction each: raise start with a circle
// on i_circle while busy is low. The transaction with last_circle set closes
// the set (its circle is stored too, unless the store already holds
// MAX_CIRCLES) and raises busy. Every circle that wholly
// contains a circle ranked after it (by descending radius, lower position
// first on ties) is then dropped, and the survivors come out on o_result in
// load order, one per o_valid strobe, the final one with last_survivor set.
// The pass reads every ordered pair of stored circles through the single
// read port of the circle memory, waits for the test pipeline to drain,
// then reads each circle once more while survivors leave one per cycle.
// busy is high for the whole pass and the final result strobe falls in the
// first cycle with busy low again.
// Results cannot be held off: each is on the ports for exactly one cycle.
// Reset empties the set and drops any pass in progress; the circle memory
// is not cleared, since only loaded entries are read.
module covering_circle_remover #(
    parameter int unsigned MAX_CIRCLES = ccr_pkg::MAX_CIRCLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire ccr_pkg::t_circle_in i_circle,
    output logic                     busy,
    output logic                     o_valid,
    output ccr_pkg::t_circle_out     o_result
);

`include "covering_circle_remover_assert.svh"

    localparam int unsigned IW        = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int unsigned CNTW      = $clog2(MAX_CIRCLES + 1);
    localparam int unsigned XW        = ccr_pkg::IDX_BITS;
    localparam int unsigned DRAIN_CYC = 4;
    localparam int unsigned DW        = $clog2(DRAIN_CYC);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RDA,
        S_LATCH,
        S_SWEEP,
        S_DRAIN,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state               r_state;
    logic [CNTW-1:0]      r_count;
    logic [IW-1:0]        r_a, r_b, r_e, r_emit_idx;
    logic [DW-1:0]        r_drain;
    logic [MAX_CIRCLES-1:0] r_drop;
    ccr_pkg::t_circle     r_a_data;
    ccr_pkg::t_pair       r_rd_pair;
    logic                 r_emit_vld;
    logic                 r_out_valid;
    ccr_pkg::t_circle_out r_out;

    logic                 n_accept, n_we;
    logic [IW-1:0]        n_raddr;
    logic [CNTW-1:0]      n_last_idx;
    ccr_pkg::t_pair       n_pair;
    ccr_pkg::t_circle     n_wdata;
    ccr_pkg::t_circle     w_rdata;
    ccr_pkg::t_hit        w_hit;
    logic [MAX_CIRCLES-1:0] n_kept_above;
    logic                 n_out_valid;
    ccr_pkg::t_circle_out n_out;

    // Load handshake and memory write.
    always_comb begin
        n_accept       = start && (r_state == S_LOAD);
        n_we           = n_accept && (r_count < CNTW'(MAX_CIRCLES));
        n_wdata.x      = i_circle.center_x;
        n_wdata.y      = i_circle.center_y;
        n_wdata.radius = i_circle.radius;
        n_last_idx     = r_count - CNTW'(1);
    end

    // Read address by phase: candidate a, partner b, or emit position.
    always_comb begin
        unique case (r_state)
            S_RDA:   n_raddr = r_a;
            S_SWEEP: n_raddr = r_b;
            S_EMIT:  n_raddr = r_e;
            default: n_raddr = r_a;
        endcase
        n_pair.valid = (r_state == S_SWEEP);
        n_pair.a_idx = XW'(r_a);
        n_pair.b_idx = XW'(r_b);
    end

    ccr_mem #(
        .DEPTH (MAX_CIRCLES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    ccr_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (r_rd_pair),
        .i_a     (r_a_data),
        .i_b     (w_rdata),
        .o_hit   (w_hit)
    );

    // Survivor selection: the result is last when no kept circle follows it.
    always_comb begin
        for (int i = 0; i < int'(MAX_CIRCLES); i++) begin
            n_kept_above[i] = !r_drop[i] && (CNTW'(i) < r_count) &&
                              (IW'(i) > r_emit_idx);
        end
        n_out_valid         = r_emit_vld && !r_drop[r_emit_idx];
        n_out.circle_index  = XW'(r_emit_idx);
        n_out.out_x         = w_rdata.x;
        n_out.out_y         = w_rdata.y;
        n_out.out_radius    = w_rdata.radius;
        n_out.last_survivor = ~|n_kept_above;
    end

    // Sequencer, drop flags and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_LOAD;
            r_count         <= '0;
            r_a             <= '0;
            r_b             <= '0;
            r_e             <= '0;
            r_drain         <= '0;
            r_drop          <= '0;
            r_rd_pair.valid <= 1'b0;
            r_emit_vld      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_rd_pair   <= n_pair;
            r_emit_vld  <= (r_state == S_EMIT);
            r_emit_idx  <= r_e;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;

            if (w_hit.valid) begin
                r_drop[w_hit.a_idx[IW-1:0]] <= 1'b1;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (n_accept) begin
                        if (n_we) begin
                            r_count <= r_count + CNTW'(1);
                        end
                        if (i_circle.last_circle) begin
                            r_a     <= '0;
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: begin
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_a_data <= w_rdata;
                    r_b      <= '0;
                    r_state  <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (CNTW'(r_b) == n_last_idx) begin
                        if (CNTW'(r_a) == n_last_idx) begin
                            r_drain <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_a     <= r_a + IW'(1);
                            r_state <= S_RDA;
                        end
                    end else begin
                        r_b <= r_b + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_drain == DW'(DRAIN_CYC - 1)) begin
                        r_e     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_drain <= r_drain + DW'(1);
                    end
                end
                S_EMIT: begin
                    if (CNTW'(r_e) == n_last_idx) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_e <= r_e + IW'(1);
                    end
                end
                S_FLUSH: begin
                    r_count <= '0;
                    r_drop  <= '0;
                    r_state <= S_LOAD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_LOAD);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // A pass never runs over an empty set.
    `CCR_ASSERT_NOW(a_sweep_nonempty, i_clk, i_rst_n, r_state == S_SWEEP, r_count != '0)
    // All containment results land before survivors are read out.
    `CCR_ASSERT_NOW(a_hit_before_emit, i_clk, i_rst_n, w_hit.valid,
        r_state != S_EMIT && r_state != S_FLUSH && r_state != S_LOAD)
    // The set is emptied once its survivors are out.
    `CCR_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, r_state == S_FLUSH,
        r_count == '0 && r_drop == '0)

endmodule

`default_nettype wire

// ===== sim/covering_circle_remover_tb.sv =====
`timescale 1ns / 1ps

module covering_circle_remover_tb;

    localparam int unsigned CIRCLE_SLOTS = ccr_pkg::MAX_CIRCLES_DEF;
    localparam int unsigned TOTAL_ITEMS  = 230;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned CW           = ccr_pkg::COORD_BITS;
    localparam int unsigned RW           = ccr_pkg::RAD_BITS;
    localparam int unsigned XW           = ccr_pkg::IDX_BITS;
    localparam int unsigned IN_BITS      = $bits(ccr_pkg::t_circle_in);
    localparam int          COORD_MAX    = int'((1 << (CW - 1)) - 1);
    localparam int          COORD_MIN    = -COORD_MAX - 1;
    localparam int          RADIUS_MAX   = int'((1 << RW) - 1);

    // Predicts the survivors of each set and checks them in load order.
    class survivor_scoreboard;
        ccr_pkg::t_circle     held[CIRCLE_SLOTS];
        int unsigned          held_count;
        ccr_pkg::t_circle_out expected_survivors[$];
        int unsigned          error_count;

        function new();
            held_count  = 0;
            error_count = 0;
        endfunction

        // True when circle a wholly contains circle b, tested without a root.
        function bit covers(int unsigned a, int unsigned b);
            longint          dx, dy, dr;
            longint unsigned dx2, dy2, dr2;
            if (held[a].radius < held[b].radius)
                return 1'b0;
            dr = longint'(held[a].radius) - longint'(held[b].radius);
            dx = longint'(held[a].x) - longint'(held[b].x);
            dy = longint'(held[a].y) - longint'(held[b].y);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            dx2 = dx * dx;
            dy2 = dy * dy;
            dr2 = dr * dr;
            if (dx2 > dr2)
                return 1'b0;
            return dy2 <= dr2 - dx2;
        endfunction

        // True when circle b ranks after circle a: larger radius first,
        // lower load position first on equal radii.
        function bit ranked_after(int unsigned a, int unsigned b);
            if (held[a].radius != held[b].radius)
                return held[a].radius > held[b].radius;
            return a < b;
        endfunction

        // Records an accepted circle; a closing circle yields the survivors.
        function void note_circle(ccr_pkg::t_circle_in c);
            bit                   dropped[CIRCLE_SLOTS];
            int unsigned          final_idx;
            ccr_pkg::t_circle_out r;
            if (held_count < CIRCLE_SLOTS) begin
                held[held_count].x      = c.center_x;
                held[held_count].y      = c.center_y;
                held[held_count].radius = c.radius;
                held_count++;
            end
            if (!c.last_circle)
                return;
            for (int unsigned a = 0; a < held_count; a++) begin
                dropped[a] = 1'b0;
                for (int unsigned b = 0; b < held_count; b++) begin
                    if (b != a && ranked_after(a, b) && covers(a, b)) begin
                        dropped[a] = 1'b1;
                        break;
                    end
                end
            end
            final_idx = 0;
            for (int unsigned a = 0; a < held_count; a++)
                if (!dropped[a])
                    final_idx = a;
            for (int unsigned a = 0; a < held_count; a++) begin
                if (!dropped[a]) begin
                    r.circle_index  = XW'(a);
                    r.out_x         = held[a].x;
                    r.out_y         = held[a].y;
                    r.out_radius    = held[a].radius;
                    r.last_survivor = (a == final_idx);
                    expected_survivors = {expected_survivors, r};
                end
            end
            held_count = 0;
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                error_count++;
            end
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_survivor(ccr_pkg::t_circle_out got);
            ccr_pkg::t_circle_out want;
            if (expected_survivors.size() == 0) begin
                $display("%0t: unexpected survivor, expected none, actual index %0d",
                         $time, got.circle_index);
                error_count++;
                return;
            end
            want = expected_survivors.pop_front();
            field_check("circle_index", 32'(want.circle_index), 32'(got.circle_index));
            field_check("out_x", 32'(want.out_x), 32'(got.out_x));
            field_check("out_y", 32'(want.out_y), 32'(got.out_y));
            field_check("out_radius", 32'(want.out_radius), 32'(got.out_radius));
            field_check("last_survivor", 32'(want.last_survivor), 32'(got.last_survivor));
        endfunction
    endclass

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 start    = 1'b0;
    ccr_pkg::t_circle_in  i_circle = '0;
    logic                 busy;
    logic                 o_valid;
    ccr_pkg::t_circle_out o_result;

    survivor_scoreboard survivors;
    int unsigned        items_sent;
    int unsigned        cycle_count;

    covering_circle_remover i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_circle (i_circle),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            survivors.check_survivor(o_result);
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Random gap before a transaction; junk sits on the data while start is low.
    task automatic idle_gap(input bit steady);
        int unsigned        roll;
        int unsigned        gap;
        logic [IN_BITS-1:0] junk;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(4, 40);
        if (gap > 0) begin
            junk = IN_BITS'({$urandom, $urandom, $urandom});
            start    <= 1'b0;
            i_circle <= junk;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds start and the circle until the block takes the transaction.
    task automatic send_circle(input ccr_pkg::t_circle_in c, input bit steady);
        idle_gap(steady);
        start    <= 1'b1;
        i_circle <= c;
        do
            @(posedge i_clk);
        while (busy);
        survivors.note_circle(c);
        items_sent++;
    endtask

    task automatic directed_circle(input int x, input int y, input int r, input bit last);
        ccr_pkg::t_circle_in c;
        c.center_x    = CW'(x);
        c.center_y    = CW'(y);
        c.radius      = RW'(r);
        c.last_circle = last;
        send_circle(c, 1'b0);
    endtask

    // Full-range circle, or one near a common base so that nesting is frequent.
    function automatic ccr_pkg::t_circle_in random_circle(input bit wide, input int base_x,
                                                          input int base_y,
                                                          input int unsigned shift);
        ccr_pkg::t_circle_in c;
        logic [IN_BITS-1:0]  raw;
        if (wide) begin
            raw = IN_BITS'({$urandom, $urandom, $urandom});
            c   = raw;
        end else begin
            c.center_x = CW'(base_x + ((int'($urandom_range(0, 80)) - 40) <<< shift));
            c.center_y = CW'(base_y + ((int'($urandom_range(0, 80)) - 40) <<< shift));
            c.radius   = RW'($urandom_range(0, 48) << shift);
        end
        c.last_circle = 1'b0;
        return c;
    endfunction

    // One set of n circles; repeats of the previous circle test the tie rule.
    task automatic run_set(input int unsigned n, input int unsigned mode, input bit steady);
        ccr_pkg::t_circle_in c;
        ccr_pkg::t_circle_in prev;
        int                  base_x;
        int                  base_y;
        int unsigned         shift;
        bit                  wide;
        base_x = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        base_y = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        shift  = $urandom_range(0, 16);
        prev   = '0;
        for (int unsigned i = 0; i < n; i++) begin
            wide = (mode == 2) || (mode == 3 && $urandom_range(0, 1) == 1);
            c = random_circle(wide, base_x, base_y, shift);
            if (i > 0 && $urandom_range(0, 7) == 0)
                c = prev;
            c.last_circle = (i == n - 1);
            send_circle(c, steady);
            prev = c;
        end
    endtask

    initial begin
        int unsigned set_no;
        int unsigned n;
        survivors  = new();
        items_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single circle at the field extremes.
        directed_circle(COORD_MIN, COORD_MAX, RADIUS_MAX, 1'b1);

        // Internal tangency, identical circles, identical points, disjoint pair.
        directed_circle(0, 0, 10, 1'b0);
        directed_circle(3, 4, 5, 1'b0);
        directed_circle(100, 100, 7, 1'b0);
        directed_circle(100, 100, 7, 1'b0);
        directed_circle(-50, -50, 0, 1'b0);
        directed_circle(-50, -50, 0, 1'b0);
        directed_circle(1000, 0, 20, 1'b0);
        directed_circle(1000, 26, 5, 1'b1);

        // Extreme coordinates and radii, one nested pair at a corner.
        directed_circle(COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b0);
        directed_circle(COORD_MIN, COORD_MIN, 0, 1'b0);
        directed_circle(COORD_MIN, COORD_MAX, RADIUS_MAX, 1'b0);
        directed_circle(COORD_MAX, COORD_MIN, 1, 1'b0);
        directed_circle(COORD_MIN, COORD_MIN, RADIUS_MAX, 1'b0);
        directed_circle(0, 0, RADIUS_MAX, 1'b1);

        // The closing circle is dropped, so an earlier one carries the last mark.
        directed_circle(0, 0, 1, 1'b0);
        directed_circle(0, 0, 100, 1'b1);

        // Random sets, mostly small; one overfills the store.
        set_no = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (set_no == 5)
                n = CIRCLE_SLOTS + 2;
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(11, 24);
            else
                n = $urandom_range(1, 10);
            run_set(n, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
            set_no++;
        end
        start <= 1'b0;

        // Drain the last set.
        while (busy || survivors.expected_survivors.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (survivors.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
